### rtl/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types, codes and lookup functions for the keyboard report translator.
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int unsigned SLOT_COUNT_DEF = 4;

   localparam logic [7:0] KEYCODE_INSERT = 8'h49;
   localparam logic [7:0] KEY_DIGIT_1    = 8'h1E;
   localparam logic [7:0] KEY_DIGIT_4    = 8'h21;
   localparam logic [7:0] KEY_DIGIT_0    = 8'h27;
   localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;

   localparam logic [7:0] ID_MEDIA       = 8'h02;
   localparam logic [7:0] ID_MACRO       = 8'h03;
   localparam logic [7:0] ID_LIGHT_DATA  = 8'h04;

   localparam logic [7:0] SEL_ZONE_A     = 8'h01;
   localparam logic [7:0] SEL_ZONE_B     = 8'h02;
   localparam logic [7:0] SEL_MODE_BTN   = 8'h04;
   localparam logic [7:0] SEL_END        = 8'h00;

   localparam logic [6:0] LEN_MEDIA      = 7'd2;
   localparam logic [6:0] LEN_SHORT      = 7'd4;
   localparam logic [6:0] LEN_KEYBOARD   = 7'd8;

   typedef enum logic [2:0] {
      ACT_KEYBOARD    = 3'd0,
      ACT_CONSUMER    = 3'd1,
      ACT_SWITCH      = 3'd2,
      ACT_SWITCH_PAIR = 3'd3,
      ACT_FACTORY     = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'd0,
      SEQ_HEAD = 2'd1,
      SEQ_TAIL = 2'd2
   } seq_state_type;

   typedef struct packed {
      logic          hit;
      seq_state_type next;
   } seq_result_type;

   typedef struct packed {
      action_type  action;
      logic [1:0]  target_slot;
      logic [63:0] report_data;
      logic        last_of_run;
   } result_type;

   // one lighting sequence filter: head, data, tail
   function automatic seq_result_type seq_filter(input seq_state_type st,
                                                 input logic [7:0]    sel,
                                                 input logic [6:0]    len,
                                                 input logic [7:0]    b0,
                                                 input logic [7:0]    b3);
      seq_result_type r;
      r.hit  = 1'b0;
      r.next = st;
      if (len == LEN_SHORT && b0 == ID_MACRO && b3 == sel) begin
         r.hit  = 1'b1;
         r.next = SEQ_HEAD;
      end else if (st == SEQ_HEAD && len == LEN_KEYBOARD && b0 == ID_LIGHT_DATA) begin
         r.hit  = 1'b1;
         r.next = SEQ_TAIL;
      end else if (st == SEQ_TAIL && len == LEN_SHORT && b0 == ID_MACRO
                   && b3 == SEL_END) begin
         r.hit  = 1'b1;
         r.next = SEQ_IDLE;
      end
      return r;
   endfunction

   function automatic logic [15:0] media_usage(input logic [7:0] v);
      logic [15:0] u;
      case (v)
         8'h01:   u = 16'h00B5;
         8'h02:   u = 16'h00B6;
         8'h04:   u = 16'h00B7;
         8'h08:   u = 16'h00CD;
         8'h10:   u = 16'h00E9;
         8'h20:   u = 16'h00EA;
         8'h40:   u = 16'h00E2;
         default: u = 16'h0000;
      endcase
      return u;
   endfunction

   // mode byte overrides the group byte
   function automatic logic [7:0] macro_code(input logic [7:0] g, input logic [7:0] m);
      logic [7:0] c;
      case (g)
         8'h01:   c = 8'h68;
         8'h02:   c = 8'h69;
         8'h04:   c = 8'h6A;
         8'h08:   c = 8'h6B;
         8'h10:   c = 8'h6C;
         8'h20:   c = 8'h6D;
         default: c = 8'h00;
      endcase
      case (m)
         8'h10:   c = 8'h6E;
         8'h20:   c = 8'h6F;
         8'h40:   c = 8'h70;
         8'h80:   c = 8'h71;
         default: c = c;
      endcase
      return c;
   endfunction

endpackage

### rtl/keyboard_report_translator.sv
// path: a request goes into the input register, then its first result into the result register
// throughput: one request per cycle when it gives zero or one result and rsp_stall is
// low; a pending release report holds the next request; set by the single result register
// reset: synchronous, clears the request and result valids, the pending release and
// the three lighting sequence states
// ----------------------------------------------------------------------------
// keyboard_report_translator
// Filters lighting sequences, decodes slot and factory commands, forwards keyboard
// reports, and media and macro reports each followed by a release report.
// ----------------------------------------------------------------------------
module keyboard_report_translator
   import krt_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [6:0]  req_report_length,
   input  logic [7:0]  req_report_byte_0,
   input  logic [7:0]  req_report_byte_1,
   input  logic [7:0]  req_report_byte_2,
   input  logic [7:0]  req_report_byte_3,
   input  logic [7:0]  req_report_byte_4,
   input  logic [7:0]  req_report_byte_5,
   input  logic [7:0]  req_report_byte_6,
   input  logic [7:0]  req_report_byte_7,
   input  logic        req_link_connected,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [1:0]  rsp_target_slot,
   output logic [63:0] rsp_report_data,
   output logic        rsp_last_of_run
);

   localparam logic [2:0] SLOT_LIMIT = 3'(SLOT_COUNT);

   // request register
   logic          req_valid_ff, req_valid_in;
   logic [6:0]    len_ff;
   logic [7:0]    byte_ff [8];
   logic          link_ff;

   // sequence states
   seq_state_type zone_a_ff, zone_a_in;
   seq_state_type zone_b_ff, zone_b_in;
   seq_state_type mode_btn_ff, mode_btn_in;

   // result register and pending release
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_ff, rsp_in;
   logic          rel_pend_ff, rel_pend_in;
   action_type    rel_action_ff, rel_action_in;

   // decode
   seq_result_type hit_a, hit_b, hit_m;
   logic          swallow;
   logic          shift, insert, has_digit, digit_zero;
   logic [1:0]    digit_val;
   logic [1:0]    cnt;
   logic          factory;
   result_type    first_res;
   action_type    rel_action;
   logic [15:0]   usage;
   logic [7:0]    mcode;

   logic          req_accept, consume, out_free, out_load;

   always_comb begin
      hit_a   = seq_filter(zone_a_ff, SEL_ZONE_A, len_ff, byte_ff[0], byte_ff[3]);
      hit_b   = seq_filter(zone_b_ff, SEL_ZONE_B, len_ff, byte_ff[0], byte_ff[3]);
      hit_m   = seq_filter(mode_btn_ff, SEL_MODE_BTN, len_ff, byte_ff[0], byte_ff[3]);
      swallow = hit_a.hit || hit_b.hit || hit_m.hit;

      shift      = (byte_ff[0] & MOD_SHIFT_MASK) != 8'h00;
      insert     = 1'b0;
      has_digit  = 1'b0;
      digit_zero = 1'b0;
      digit_val  = 2'd0;
      // highest byte position wins
      for (int i = 2; i < 8; i++) begin
         if (byte_ff[i] == KEYCODE_INSERT) insert = 1'b1;
         if (byte_ff[i] >= KEY_DIGIT_1 && byte_ff[i] <= KEY_DIGIT_4) begin
            has_digit  = 1'b1;
            digit_zero = 1'b0;
            digit_val  = 2'(byte_ff[i] - KEY_DIGIT_1);
         end
         if (byte_ff[i] == KEY_DIGIT_0) begin
            has_digit  = 1'b1;
            digit_zero = 1'b1;
         end
      end

      usage = media_usage(byte_ff[1]);
      mcode = macro_code(byte_ff[1], byte_ff[2]);

      cnt                   = 2'd0;
      factory               = 1'b0;
      rel_action            = ACT_KEYBOARD;
      first_res.action      = ACT_KEYBOARD;
      first_res.target_slot = 2'd0;
      first_res.report_data = 64'd0;
      first_res.last_of_run = 1'b1;

      if (swallow) begin
         cnt = 2'd0;
      end else if (len_ff == LEN_KEYBOARD) begin
         if (insert && has_digit) begin
            if (digit_zero) begin
               if (shift) begin
                  cnt              = 2'd1;
                  factory          = 1'b1;
                  first_res.action = ACT_FACTORY;
               end
            end else if ({1'b0, digit_val} < SLOT_LIMIT) begin
               cnt                   = 2'd1;
               first_res.action      = shift ? ACT_SWITCH_PAIR : ACT_SWITCH;
               first_res.target_slot = digit_val;
            end
         end else if (link_ff) begin
            cnt                   = 2'd1;
            first_res.report_data = {byte_ff[7], byte_ff[6], byte_ff[5], byte_ff[4],
                                     byte_ff[3], byte_ff[2], byte_ff[1], byte_ff[0]};
         end
      end else if (len_ff == LEN_MEDIA && byte_ff[0] == ID_MEDIA) begin
         if (link_ff && usage != 16'd0) begin
            cnt                   = 2'd2;
            first_res.action      = ACT_CONSUMER;
            first_res.report_data = {48'd0, usage};
            first_res.last_of_run = 1'b0;
            rel_action            = ACT_CONSUMER;
         end
      end else if (len_ff == LEN_SHORT && byte_ff[0] == ID_MACRO) begin
         if (link_ff && mcode != 8'd0) begin
            cnt                   = 2'd2;
            first_res.report_data = {40'd0, mcode, 16'd0};
            first_res.last_of_run = 1'b0;
         end
      end
   end

   // handshake control
   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      consume    = req_valid_ff && !rel_pend_ff && (cnt == 2'd0 || out_free);
      out_load   = out_free && (rel_pend_ff || (req_valid_ff && cnt != 2'd0));
      req_stall  = req_valid_ff && !consume;
      req_accept = req_valid && !req_stall;
   end

   always_comb begin
      req_valid_in = req_accept || (req_valid_ff && !consume);

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) rsp_valid_in = 1'b1;

      rsp_in        = rsp_ff;
      rel_pend_in   = rel_pend_ff;
      rel_action_in = rel_action_ff;
      if (out_load) begin
         if (rel_pend_ff) begin
            rsp_in.action      = rel_action_ff;
            rsp_in.target_slot = 2'd0;
            rsp_in.report_data = 64'd0;
            rsp_in.last_of_run = 1'b1;
            rel_pend_in        = 1'b0;
         end else begin
            rsp_in        = first_res;
            rel_pend_in   = (cnt == 2'd2);
            rel_action_in = rel_action;
         end
      end

      zone_a_in   = zone_a_ff;
      zone_b_in   = zone_b_ff;
      mode_btn_in = mode_btn_ff;
      if (consume) begin
         if (hit_a.hit) begin
            zone_a_in = hit_a.next;
         end else if (hit_b.hit) begin
            zone_b_in = hit_b.next;
         end else if (hit_m.hit) begin
            mode_btn_in = hit_m.next;
         end else if (factory) begin
            zone_a_in   = SEQ_IDLE;
            zone_b_in   = SEQ_IDLE;
            mode_btn_in = SEQ_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rel_pend_ff  <= 1'b0;
         zone_a_ff    <= SEQ_IDLE;
         zone_b_ff    <= SEQ_IDLE;
         mode_btn_ff  <= SEQ_IDLE;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rel_pend_ff  <= rel_pend_in;
         zone_a_ff    <= zone_a_in;
         zone_b_ff    <= zone_b_in;
         mode_btn_ff  <= mode_btn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         len_ff     <= req_report_length;
         byte_ff[0] <= req_report_byte_0;
         byte_ff[1] <= req_report_byte_1;
         byte_ff[2] <= req_report_byte_2;
         byte_ff[3] <= req_report_byte_3;
         byte_ff[4] <= req_report_byte_4;
         byte_ff[5] <= req_report_byte_5;
         byte_ff[6] <= req_report_byte_6;
         byte_ff[7] <= req_report_byte_7;
         link_ff    <= req_link_connected;
      end
      rsp_ff        <= rsp_in;
      rel_action_ff <= rel_action_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_ff.action;
   assign rsp_target_slot = rsp_ff.target_slot;
   assign rsp_report_data = rsp_ff.report_data;
   assign rsp_last_of_run = rsp_ff.last_of_run;

endmodule
